// ===== design/e2q_pkg.sv =====
`timescale 1ns / 1ps

package e2q_pkg;

  // Field widths of the angle inputs and the quaternion outputs.
  localparam int ANGLE_W = 16;
  localparam int COMP_W  = 16;

  // Phase is carried in units of 2^-32 turn.
  localparam int PHASE_W = 32;

  // CORDIC datapath: x and y are Q2.30 with headroom, results Q1.30 in 32 bits.
  localparam int CORDIC_STEPS    = 30;
  localparam int STEPS_PER_STAGE = 3;
  localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;
  localparam int XY_W            = 34;
  localparam int TRIG_W          = 32;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

  // Product widths.
  localparam int PROD_W = 2 * TRIG_W;
  localparam int SUM_W  = PROD_W + 1;

  // Axis lanes.
  localparam int NUM_AXES  = 3;
  localparam int AXIS_YAW   = 0;
  localparam int AXIS_PITCH = 1;
  localparam int AXIS_ROLL  = 2;

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam logic [PHASE_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  // Rotator state of one lane.
  typedef struct packed {
    logic signed [XY_W-1:0]    x;
    logic signed [XY_W-1:0]    y;
    logic signed [PHASE_W-1:0] z;
  } cordic_vec_t;

  // Cosine and sine of one half angle, Q1.30.
  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } trig_t;

  // Scales the binary angle to a full 32-bit phase and halves it with floor.
  function automatic logic signed [PHASE_W-1:0] half_phase(input logic [ANGLE_W-1:0] ang);
    logic [PHASE_W-1:0] p;
    p = PHASE_W'(ang) << (PHASE_W - ANGLE_W);
    return $signed(p) >>> 1;
  endfunction

endpackage

// ===== design/e2q_cordic.sv =====
`timescale 1ns / 1ps

module e2q_cordic
  import e2q_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  cordic_vec_t vec_in  [NUM_AXES],
  output logic        out_vld,
  output trig_t       trig_out [NUM_AXES]
);

  cordic_vec_t stage_in  [CORDIC_STAGES][NUM_AXES];
  cordic_vec_t stage_nxt [CORDIC_STAGES][NUM_AXES];
  cordic_vec_t stage_r   [CORDIC_STAGES][NUM_AXES];
  logic [CORDIC_STAGES-1:0] vld_r;

  genvar s, a;
  generate
    for (s = 0; s < CORDIC_STAGES; s++) begin : g_stage
      for (a = 0; a < NUM_AXES; a++) begin : g_axis
        // The first stage takes the prepared vector, later ones the stage before.
        if (s == 0) begin : g_first
          assign stage_in[s][a] = vec_in[a];
        end else begin : g_next
          assign stage_in[s][a] = stage_r[s-1][a];
        end

        // A few rotation steps per stage, each with a fixed shift and angle.
        always_comb begin
          cordic_vec_t v;
          logic signed [XY_W-1:0] dx;
          logic signed [XY_W-1:0] dy;
          v = stage_in[s][a];
          for (int k = 0; k < STEPS_PER_STAGE; k++) begin
            dx = v.y >>> (s * STEPS_PER_STAGE + k);
            dy = v.x >>> (s * STEPS_PER_STAGE + k);
            if (!v.z[PHASE_W-1]) begin
              v.x = v.x - dx;
              v.y = v.y + dy;
              v.z = v.z - $signed(ATAN_TURNS[s * STEPS_PER_STAGE + k]);
            end else begin
              v.x = v.x + dx;
              v.y = v.y - dy;
              v.z = v.z + $signed(ATAN_TURNS[s * STEPS_PER_STAGE + k]);
            end
          end
          stage_nxt[s][a] = v;
        end

        always_ff @(posedge clk) begin
          if (en) begin
            stage_r[s][a] <= stage_nxt[s][a];
          end
        end
      end
    end

    // Results are within one turn of the gain, so the low bits carry them.
    for (a = 0; a < NUM_AXES; a++) begin : g_out
      assign trig_out[a].cos_v = stage_r[CORDIC_STAGES-1][a].x[TRIG_W-1:0];
      assign trig_out[a].sin_v = stage_r[CORDIC_STAGES-1][a].y[TRIG_W-1:0];
    end
  endgenerate

  // Valid bits move along with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[CORDIC_STAGES-2:0], in_vld};
    end
  end

  assign out_vld = vld_r[CORDIC_STAGES-1];

endmodule

// ===== design/e2q_combine.sv =====
`timescale 1ns / 1ps

module e2q_combine
  import e2q_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  trig_t                    trig_in [NUM_AXES],
  output logic                     out_vld,
  output logic signed [COMP_W-1:0] quat_w,
  output logic signed [COMP_W-1:0] quat_x,
  output logic signed [COMP_W-1:0] quat_y,
  output logic signed [COMP_W-1:0] quat_z
);

  localparam int RND_SH  = 60 - (COMP_W - 1);
  localparam logic signed [PROD_W-1:0] RND_HALF1 = PROD_W'(1) << 29;
  localparam logic signed [SUM_W-1:0]  RND_HALF2 = SUM_W'(1) << (RND_SH - 1);
  localparam logic signed [SUM_W-1:0]  SAT_HI    = (SUM_W'(1) << (COMP_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0]  SAT_LO    = -SAT_HI - SUM_W'(1);

  logic [4:0] vld_r;

  logic signed [TRIG_W-1:0] cy, sy, cp, sp, cr, sr;
  assign cy = trig_in[AXIS_YAW].cos_v;
  assign sy = trig_in[AXIS_YAW].sin_v;
  assign cp = trig_in[AXIS_PITCH].cos_v;
  assign sp = trig_in[AXIS_PITCH].sin_v;
  assign cr = trig_in[AXIS_ROLL].cos_v;
  assign sr = trig_in[AXIS_ROLL].sin_v;

  // Rounds a Q60 sum to the output format and clamps it.
  function automatic logic signed [COMP_W-1:0] to_comp(input logic signed [SUM_W-1:0] q60);
    logic signed [SUM_W-1:0] t;
    t = (q60 + RND_HALF2) >>> RND_SH;
    if (t > SAT_HI) begin
      t = SAT_HI;
    end else if (t < SAT_LO) begin
      t = SAT_LO;
    end
    return t[COMP_W-1:0];
  endfunction

  // Stage 1: yaw times pitch products.
  logic signed [PROD_W-1:0] p_cc_r, p_ss_r, p_sc_r, p_cs_r;
  logic signed [TRIG_W-1:0] cr1_r, sr1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p_cc_r <= cy * cp;
      p_ss_r <= sy * sp;
      p_sc_r <= sy * cp;
      p_cs_r <= cy * sp;
      cr1_r  <= cr;
      sr1_r  <= sr;
    end
  end

  // Stage 2: round the pair products back to Q30.
  logic signed [PROD_W-1:0] t_cc, t_ss, t_sc, t_cs;
  logic signed [TRIG_W-1:0] r_cc_r, r_ss_r, r_sc_r, r_cs_r;
  logic signed [TRIG_W-1:0] cr2_r, sr2_r;
  always_comb begin
    t_cc = p_cc_r + RND_HALF1;
    t_ss = p_ss_r + RND_HALF1;
    t_sc = p_sc_r + RND_HALF1;
    t_cs = p_cs_r + RND_HALF1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      r_cc_r <= t_cc[30 +: TRIG_W];
      r_ss_r <= t_ss[30 +: TRIG_W];
      r_sc_r <= t_sc[30 +: TRIG_W];
      r_cs_r <= t_cs[30 +: TRIG_W];
      cr2_r  <= cr1_r;
      sr2_r  <= sr1_r;
    end
  end

  // Stage 3: multiply by the roll terms.
  logic signed [PROD_W-1:0] w_a_r, w_b_r, x_a_r, x_b_r, y_a_r, y_b_r, z_a_r, z_b_r;
  always_ff @(posedge clk) begin
    if (en) begin
      w_a_r <= r_cc_r * cr2_r;
      w_b_r <= r_ss_r * sr2_r;
      x_a_r <= r_cc_r * sr2_r;
      x_b_r <= r_ss_r * cr2_r;
      y_a_r <= r_sc_r * sr2_r;
      y_b_r <= r_cs_r * cr2_r;
      z_a_r <= r_sc_r * cr2_r;
      z_b_r <= r_cs_r * sr2_r;
    end
  end

  // Stage 4: form the four Q60 components.
  logic signed [SUM_W-1:0] sum_w_r, sum_x_r, sum_y_r, sum_z_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sum_w_r <= SUM_W'(w_a_r) + SUM_W'(w_b_r);
      sum_x_r <= SUM_W'(x_a_r) - SUM_W'(x_b_r);
      sum_y_r <= SUM_W'(y_a_r) + SUM_W'(y_b_r);
      sum_z_r <= SUM_W'(z_a_r) - SUM_W'(z_b_r);
    end
  end

  // Stage 5: round, saturate and hold the result for the receiver.
  logic signed [COMP_W-1:0] qw_r, qx_r, qy_r, qz_r;
  always_ff @(posedge clk) begin
    if (en) begin
      qw_r <= to_comp(sum_w_r);
      qx_r <= to_comp(sum_x_r);
      qy_r <= to_comp(sum_y_r);
      qz_r <= to_comp(sum_z_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  assign out_vld = vld_r[4];
  assign quat_w  = qw_r;
  assign quat_x  = qx_r;
  assign quat_y  = qy_r;
  assign quat_z  = qz_r;

endmodule

// ===== design/euler_to_quaternion_unit.sv =====
`timescale 1ns / 1ps
// Euler angles to quaternion, Z-Y-X order (yaw about z, pitch about y, roll about x).
// Input channel: in_valid/in_ready with in_yaw_angle, in_pitch_angle, in_roll_angle,
// signed binary angles where 65536 is one full turn.
// Output channel: out_valid/out_ready with out_quat_w/x/y/z in signed Q1.15;
// a component of +1.0 saturates to 32767.
// One pose is taken per cycle while in_ready is high, and each gives exactly one result.
// The angles are halved in a register stage, then pass ten CORDIC stages of three
// rotation steps each and five stages of multiply, round, add and saturate.
// Throughput is one pose per cycle unless the receiver stalls, set by the fully pipelined
// CORDIC lanes and the twelve multipliers of the two product stages.
// When a result waits on a stalled receiver, the whole pipeline holds and in_ready drops;
// no item is lost or repeated, and the waiting result stays on the output ports.
// Reset clears all valid bits; no result is pending afterwards.
module euler_to_quaternion_unit
  import e2q_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [ANGLE_W-1:0] in_yaw_angle,
  input  logic signed [ANGLE_W-1:0] in_pitch_angle,
  input  logic signed [ANGLE_W-1:0] in_roll_angle,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [COMP_W-1:0]  out_quat_w,
  output logic signed [COMP_W-1:0]  out_quat_x,
  output logic signed [COMP_W-1:0]  out_quat_y,
  output logic signed [COMP_W-1:0]  out_quat_z
);

  logic        en;
  logic        prep_vld_r;
  cordic_vec_t prep_r [NUM_AXES];
  logic        cordic_vld;
  trig_t       trig [NUM_AXES];

  // The pipeline advances unless a finished result waits on a stalled receiver.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Halve each angle and seed the rotator.
  always_ff @(posedge clk) begin
    if (en) begin
      prep_r[AXIS_YAW]   <= '{x: CORDIC_GAIN, y: '0, z: half_phase(in_yaw_angle)};
      prep_r[AXIS_PITCH] <= '{x: CORDIC_GAIN, y: '0, z: half_phase(in_pitch_angle)};
      prep_r[AXIS_ROLL]  <= '{x: CORDIC_GAIN, y: '0, z: half_phase(in_roll_angle)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_vld_r <= 1'b0;
    end else if (en) begin
      prep_vld_r <= in_valid;
    end
  end

  e2q_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (prep_vld_r),
    .vec_in   (prep_r),
    .out_vld  (cordic_vld),
    .trig_out (trig)
  );

  e2q_combine u_combine (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (cordic_vld),
    .trig_in (trig),
    .out_vld (out_valid),
    .quat_w  (out_quat_w),
    .quat_x  (out_quat_x),
    .quat_y  (out_quat_y),
    .quat_z  (out_quat_z)
  );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int AW = e2q_pkg::ANGLE_W;
  localparam int CW = e2q_pkg::COMP_W;

  // Rotator constants: gain in Q30 and arctangent of 2^-i in units of 2^-32 turn.
  localparam int ROTATE_STEPS = 30;
  localparam longint ROTATOR_GAIN = 64'sd652032874;
  localparam longint ARCTAN_TURN [ROTATE_STEPS] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
  };
  localparam longint HALF_Q30 = 64'sd536870912;
  localparam int Q60_TO_OUT = 60 - (CW - 1);
  localparam longint HALF_OUT_LSB = 64'sd1 <<< (Q60_TO_OUT - 1);
  localparam longint COMP_MAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint COMP_MIN = -(64'sd1 <<< (CW - 1));

  localparam int LONG_HOLD_CYCLES = 120;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic signed [AW-1:0] yaw;
    logic signed [AW-1:0] pitch;
    logic signed [AW-1:0] roll;
  } pose_t;

  typedef struct packed {
    logic signed [CW-1:0] w;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } quat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [AW-1:0] in_yaw_angle = '0;
  logic signed [AW-1:0] in_pitch_angle = '0;
  logic signed [AW-1:0] in_roll_angle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CW-1:0] out_quat_w;
  logic signed [CW-1:0] out_quat_x;
  logic signed [CW-1:0] out_quat_y;
  logic signed [CW-1:0] out_quat_z;

  pose_t pending_poses[$];
  quat_t expected_quats[$];
  pose_t drive_pose;
  quat_t want_quat;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int hold_left = 0;
  logic long_hold_req = 1'b0;

  euler_to_quaternion_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_yaw_angle   (in_yaw_angle),
    .in_pitch_angle (in_pitch_angle),
    .in_roll_angle  (in_roll_angle),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_quat_w     (out_quat_w),
    .out_quat_x     (out_quat_x),
    .out_quat_y     (out_quat_y),
    .out_quat_z     (out_quat_z)
  );

  always #5 clk = ~clk;

  // Cosine and sine (Q30) of half the binary angle, by the rotation-mode CORDIC.
  function automatic void half_angle_trig(input logic signed [AW-1:0] ang,
                                          output longint c, output longint s);
    longint z;
    longint x;
    longint y;
    longint dx;
    longint dy;
    z = $signed({{(64 - 32){ang[AW-1]}}, ang, {(32 - AW){1'b0}}});
    z = z >>> 1;
    x = ROTATOR_GAIN;
    y = 0;
    for (int i = 0; i < ROTATE_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ARCTAN_TURN[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ARCTAN_TURN[i];
      end
    end
    c = x;
    s = y;
  endfunction

  // Product of three Q30 values in Q60, the first product rounded back to Q30.
  function automatic longint rounded_triple(input longint a, input longint b,
                                            input longint c);
    longint ab;
    ab = (a * b + HALF_Q30) >>> 30;
    return ab * c;
  endfunction

  // Q60 sum rounded to the output fraction bits and clamped.
  function automatic logic signed [CW-1:0] to_q15(input longint q60);
    longint v;
    v = (q60 + HALF_OUT_LSB) >>> Q60_TO_OUT;
    if (v > COMP_MAX) v = COMP_MAX;
    if (v < COMP_MIN) v = COMP_MIN;
    return v[CW-1:0];
  endfunction

  function automatic quat_t predict_quat(input pose_t p);
    longint cy, sy, cp, sp, cr, sr;
    quat_t q;
    half_angle_trig(p.yaw, cy, sy);
    half_angle_trig(p.pitch, cp, sp);
    half_angle_trig(p.roll, cr, sr);
    q.w = to_q15(rounded_triple(cy, cp, cr) + rounded_triple(sy, sp, sr));
    q.x = to_q15(rounded_triple(cy, cp, sr) - rounded_triple(sy, sp, cr));
    q.y = to_q15(rounded_triple(sy, cp, sr) + rounded_triple(cy, sp, cr));
    q.z = to_q15(rounded_triple(sy, cp, cr) - rounded_triple(cy, sp, sr));
    return q;
  endfunction

  // Mostly uniform angles, the rest near zero, quarter turns, octants and the wrap point.
  function automatic logic signed [AW-1:0] random_angle();
    int base;
    if ($urandom_range(99) < 70) return AW'($urandom);
    case ($urandom_range(7))
      0: base = 0;
      1: base = 16384;
      2: base = -16384;
      3: base = -32768;
      4: base = 32767;
      5: base = 8192;
      6: base = -8192;
      default: base = 24576;
    endcase
    return AW'(base + int'($urandom_range(4)) - 2);
  endfunction

  function automatic pose_t random_pose();
    pose_t p;
    p.yaw = random_angle();
    p.pitch = random_angle();
    p.roll = random_angle();
    return p;
  endfunction

  task automatic queue_pose(input int yaw, input int pitch, input int roll);
    pose_t p;
    p.yaw = AW'(yaw);
    p.pitch = AW'(pitch);
    p.roll = AW'(roll);
    pending_poses.push_back(p);
  endtask

  task automatic check_component(input string name, input logic signed [CW-1:0] want,
                                 input logic signed [CW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic wait_until_drained();
    while (pending_poses.size() != 0 || in_valid || expected_quats.size() != 0)
      @(posedge clk);
  endtask

  // Driver: records the prediction on each input transfer and offers the next pose.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        drive_pose.yaw = in_yaw_angle;
        drive_pose.pitch = in_pitch_angle;
        drive_pose.roll = in_roll_angle;
        expected_quats.push_back(predict_quat(drive_pose));
      end
      if (!in_valid || in_ready) begin
        if (pending_poses.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drive_pose = pending_poses.pop_front();
          in_valid <= 1'b1;
          in_yaw_angle <= drive_pose.yaw;
          in_pitch_angle <= drive_pose.pitch;
          in_roll_angle <= drive_pose.roll;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down here once requested.
  always @(posedge clk) begin
    if (long_hold_req) begin
      hold_left <= LONG_HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: compares each output transfer with the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_quats.size() == 0) begin
          $error("result with no pose pending: w %0d x %0d y %0d z %0d",
                 out_quat_w, out_quat_x, out_quat_y, out_quat_z);
          mismatch_count++;
        end else begin
          want_quat = expected_quats.pop_front();
          check_component("quat_w", want_quat.w, out_quat_w);
          check_component("quat_x", want_quat.x, out_quat_x);
          check_component("quat_y", want_quat.y, out_quat_y);
          check_component("quat_z", want_quat.z, out_quat_z);
        end
      end
      out_ready <= (hold_left == 0) && !long_hold_req &&
                   ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Stimulus: directed poses, then random poses under several idling mixes.
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Zero pose saturates w; half turns put the half angle at -90 degrees.
    queue_pose(0, 0, 0);
    queue_pose(-32768, 0, 0);
    queue_pose(0, -32768, 0);
    queue_pose(0, 0, -32768);
    queue_pose(32767, 0, 0);
    queue_pose(0, 32767, 0);
    queue_pose(0, 0, 32767);
    queue_pose(16384, 0, 0);
    queue_pose(0, 16384, 0);
    queue_pose(0, 0, 16384);
    queue_pose(-16384, -16384, -16384);
    queue_pose(16384, 16384, 16384);
    queue_pose(1, -1, 1);
    queue_pose(-1, 1, -1);
    queue_pose(-32768, -32768, -32768);
    queue_pose(32767, 32767, 32767);
    queue_pose(8192, -8192, 8192);
    queue_pose(-32768, 16384, 32767);
    queue_pose(21845, -21846, 21845);
    queue_pose(-21846, 21845, -21846);
    wait_until_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct <= 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct <= 65;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct <= 0;
          recv_stall_pct <= 65;
        end
        default: begin
          send_idle_pct <= 34;
          recv_stall_pct <= 34;
        end
      endcase
      repeat (135) pending_poses.push_back(random_pose());
      if (phase == 0) begin
        // Hold the output while poses keep coming so the pipeline backs up.
        repeat (5) @(posedge clk);
        long_hold_req <= 1'b1;
        @(posedge clk);
        long_hold_req <= 1'b0;
      end
      wait_until_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
